/* rtl/emn_pkg.sv */
// Shared types and constants for the encoder menu navigator.
package emn_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int COUNT_W    = 5;
  localparam int CURSOR_W   = 4;
  localparam int TIMER_W    = 16;
  localparam int ID_W       = 11;
  localparam int MENU_W     = 2;

  // Input opcodes
  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_ROTATE = 2'd1;
  localparam logic [1:0] OP_SWITCH = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BOOST_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLIP_COUNT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BOOST_ID    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SLIP_ID     = 3'd4;

  // Register reset values
  localparam logic [COUNT_W-1:0] RST_BOOST_COUNT = 5'd8;
  localparam logic [COUNT_W-1:0] RST_SLIP_COUNT  = 5'd5;
  localparam logic [TIMER_W-1:0] RST_TIMEOUT     = 16'd3000;
  localparam logic [ID_W-1:0]    RST_ID          = 11'd0;

  // Menu codes
  localparam logic [MENU_W-1:0] MENU_NONE  = 2'd0;
  localparam logic [MENU_W-1:0] MENU_BOOST = 2'd1;
  localparam logic [MENU_W-1:0] MENU_SLIP  = 2'd2;

  typedef enum logic [1:0] {
    CMD_NOP,
    CMD_TICK,
    CMD_ROTATE,
    CMD_PRESS
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e kind;
    logic      enc;
    logic      a;
    logic      b;
  } cmd_t;

  typedef struct packed {
    logic   push;
    cmd_t   cmd;
  } push_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_stat_t;

  typedef struct packed {
    logic [COUNT_W-1:0] boost_count;
    logic [COUNT_W-1:0] slip_count;
    logic [TIMER_W-1:0] timeout;
    logic [ID_W-1:0]    boost_id;
    logic [ID_W-1:0]    slip_id;
  } cfg_t;

endpackage

/* rtl/emn_if.sv */
// Request and result channel interfaces of the encoder menu navigator.
interface emn_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic       encoder_select;
  logic       pin_level;
  logic       level_b;

  modport source (output valid, opcode, encoder_select, pin_level, level_b, input ready);
  modport sink   (input valid, opcode, encoder_select, pin_level, level_b, output ready);
endinterface

interface emn_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  open_menu;
  logic [3:0]  cursor;
  logic        select_valid;
  logic [10:0] select_id;
  logic [3:0]  select_index;

  modport source (output valid, open_menu, cursor, select_valid, select_id, select_index,
                  input ready);
  modport sink   (input valid, open_menu, cursor, select_valid, select_id, select_index,
                  output ready);
endinterface

/* rtl/encoder_menu_navigator.sv */
// Top level of the two-encoder menu cursor block.
//
// Requests arrive on in_i: a millisecond tick, an encoder A level with its
// B level, or a switch level, tagged with the encoder they belong to.
// Every request yields exactly one result on out_o: the open menu, the
// cursor after the request, and a selection when a switch was pressed.
// A taken request is written into the command queue; the back end pops
// it and loads its result register. One request is taken per cycle,
// sustained while the receiver takes results: the front end classifies
// in the accept cycle, a two-entry command queue feeds the back end, and
// the back end updates state and loads the result register as it pops.
// When the receiver stalls, the result register holds, the queue fills and
// in_i.ready falls once both entries are taken.
// Reset clears the menu, cursor and timer, sets both last A levels high and
// loads the register defaults. The user writes registers through cfg_we_i,
// cfg_idx_i and cfg_data_i only while no request is in flight, unenforced.
module encoder_menu_navigator #(
  parameter int MAX_ITEMS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  emn_in_if.sink                        in_i,
  emn_out_if.source                     out_o,
  input  logic                          cfg_we_i,
  input  logic [emn_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [emn_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import emn_pkg::*;

  cfg_t       cfg_q;
  push_t      push;
  cmd_t       cmd;
  fifo_stat_t stat;
  logic       pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.boost_count <= RST_BOOST_COUNT;
      cfg_q.slip_count  <= RST_SLIP_COUNT;
      cfg_q.timeout     <= RST_TIMEOUT;
      cfg_q.boost_id    <= RST_ID;
      cfg_q.slip_id     <= RST_ID;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_BOOST_COUNT: cfg_q.boost_count <= cfg_data_i[COUNT_W-1:0];
        REG_SLIP_COUNT:  cfg_q.slip_count  <= cfg_data_i[COUNT_W-1:0];
        REG_TIMEOUT:     cfg_q.timeout     <= cfg_data_i[TIMER_W-1:0];
        REG_BOOST_ID:    cfg_q.boost_id    <= cfg_data_i[ID_W-1:0];
        REG_SLIP_ID:     cfg_q.slip_id     <= cfg_data_i[ID_W-1:0];
        default: begin
        end
      endcase
    end
  end

  emn_front u_front (
    .in_i   (in_i),
    .stat_i (stat),
    .push_o (push)
  );

  emn_cmd_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .cmd_o  (cmd),
    .stat_o (stat)
  );

  emn_back #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .cmd_i  (cmd),
    .stat_i (stat),
    .pop_o  (pop),
    .out_o  (out_o)
  );

  localparam int SPAN = (MAX_ITEMS < 16) ? MAX_ITEMS : 16;

  // a press always closes the menu
  a_select_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.select_valid |-> out_o.open_menu == MENU_NONE)
    else $error("selection reported with a menu open");

  a_cursor_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> 32'(out_o.cursor) < SPAN)
    else $error("cursor beyond menu span");

  a_menu_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> out_o.open_menu != 2'd3)
    else $error("illegal open menu code");

  a_no_select_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.select_valid |-> out_o.select_id == '0 && out_o.select_index == '0)
    else $error("selection fields set without a selection");

  // a queued command with a free result register must drain
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !stat.empty && !out_o.valid |=> out_o.valid)
    else $error("back end failed to take a queued command");

endmodule

/* rtl/emn_front.sv */
// Front end: accepts requests and classifies them into commands.
module emn_front (
  emn_in_if.sink             in_i,
  input  emn_pkg::fifo_stat_t stat_i,
  output emn_pkg::push_t      push_o
);
  import emn_pkg::*;

  cmd_kind_e kind;

  always_comb begin
    case (in_i.opcode)
      OP_TICK:   kind = CMD_TICK;
      OP_ROTATE: kind = CMD_ROTATE;
      // a release changes nothing, only a press acts
      OP_SWITCH: kind = in_i.pin_level ? CMD_NOP : CMD_PRESS;
      default:   kind = CMD_NOP;
    endcase
  end

  assign in_i.ready       = !stat_i.full;
  assign push_o.push      = in_i.valid && !stat_i.full;
  assign push_o.cmd.kind  = kind;
  assign push_o.cmd.enc   = in_i.encoder_select;
  assign push_o.cmd.a     = in_i.pin_level;
  assign push_o.cmd.b     = in_i.level_b;

endmodule

/* rtl/emn_cmd_fifo.sv */
// Two-entry command queue between front and back end.
module emn_cmd_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  emn_pkg::push_t      push_i,
  input  logic                pop_i,
  output emn_pkg::cmd_t       cmd_o,
  output emn_pkg::fifo_stat_t stat_o
);
  import emn_pkg::*;

  cmd_t       mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;

  assign stat_o.empty = (cnt_q == 2'd0);
  assign stat_o.full  = (cnt_q == 2'd2);
  assign cmd_o        = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i.push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push_i.push} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.push) begin
      mem_q[wr_ptr_q] <= push_i.cmd;
    end
  end

endmodule

/* rtl/emn_back.sv */
// Back end: menu, cursor and timer state, and the result register.
module emn_back #(
  parameter int MAX_ITEMS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  emn_pkg::cfg_t       cfg_i,
  input  emn_pkg::cmd_t       cmd_i,
  input  emn_pkg::fifo_stat_t stat_i,
  output logic                pop_o,
  emn_out_if.source           out_o
);
  import emn_pkg::*;

  localparam int SPAN = (MAX_ITEMS < 16) ? MAX_ITEMS : 16;
  localparam logic [COUNT_W-1:0] SPAN_C = COUNT_W'(SPAN);

  logic [1:0]          last_a_q, last_a_d;
  logic [MENU_W-1:0]   menu_q, menu_d;
  logic [CURSOR_W-1:0] cursor_q, cursor_d;
  logic [TIMER_W-1:0]  timer_q, timer_d;
  logic                out_valid_q, out_valid_d;
  logic                sel_valid_q, sel_valid_d;
  logic [ID_W-1:0]     sel_id_q, sel_id_d;
  logic [CURSOR_W-1:0] sel_index_q, sel_index_d;

  logic [COUNT_W-1:0]  raw_count;
  logic [COUNT_W-1:0]  count;
  logic [COUNT_W-1:0]  pos;
  logic [MENU_W-1:0]   wanted;

  assign pop_o = !stat_i.empty && (!out_valid_q || out_o.ready);

  always_comb begin
    raw_count = cmd_i.enc ? cfg_i.slip_count : cfg_i.boost_count;
    count     = raw_count;
    if (count == '0) count = COUNT_W'(1);
    if (count > SPAN_C) count = SPAN_C;
    wanted    = cmd_i.enc ? MENU_SLIP : MENU_BOOST;

    pos = {1'b0, cursor_q};
    if (cmd_i.a != cmd_i.b) begin
      pos = pos + COUNT_W'(1);
    end else if (pos != '0) begin
      pos = pos - COUNT_W'(1);
    end
    if (pos > count - COUNT_W'(1)) pos = count - COUNT_W'(1);
  end

  always_comb begin
    last_a_d    = last_a_q;
    menu_d      = menu_q;
    cursor_d    = cursor_q;
    timer_d     = timer_q;
    sel_valid_d = sel_valid_q;
    sel_id_d    = sel_id_q;
    sel_index_d = sel_index_q;
    out_valid_d = out_o.ready ? 1'b0 : out_valid_q;

    if (pop_o) begin
      out_valid_d = 1'b1;
      sel_valid_d = 1'b0;
      sel_id_d    = '0;
      sel_index_d = '0;
      case (cmd_i.kind)
        CMD_TICK: begin
          if (timer_q != '0) begin
            timer_d = timer_q - TIMER_W'(1);
            // expiry closes the menu
            if (timer_q == TIMER_W'(1)) begin
              menu_d   = MENU_NONE;
              cursor_d = '0;
            end
          end
        end
        CMD_ROTATE: begin
          if (cmd_i.a != last_a_q[cmd_i.enc]) begin
            last_a_d[cmd_i.enc] = cmd_i.a;
            if (menu_q != wanted) begin
              menu_d   = wanted;
              cursor_d = '0;
            end else begin
              cursor_d = pos[CURSOR_W-1:0];
            end
            timer_d = cfg_i.timeout;
          end
        end
        CMD_PRESS: begin
          sel_valid_d = 1'b1;
          sel_id_d    = cmd_i.enc ? cfg_i.slip_id : cfg_i.boost_id;
          sel_index_d = cursor_q;
          menu_d      = MENU_NONE;
          timer_d     = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_a_q    <= 2'b11;
      menu_q      <= MENU_NONE;
      cursor_q    <= '0;
      timer_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      last_a_q    <= last_a_d;
      menu_q      <= menu_d;
      cursor_q    <= cursor_d;
      timer_q     <= timer_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sel_valid_q <= sel_valid_d;
    sel_id_q    <= sel_id_d;
    sel_index_q <= sel_index_d;
  end

  // result reflects state after the item; state only moves on pop
  assign out_o.valid        = out_valid_q;
  assign out_o.open_menu    = menu_q;
  assign out_o.cursor       = cursor_q;
  assign out_o.select_valid = sel_valid_q;
  assign out_o.select_id    = sel_id_q;
  assign out_o.select_index = sel_index_q;

endmodule

/* tb/sv/encoder_menu_navigator_checker.sv */
// Scoreboard for the encoder menu navigator: shadows registers and menu state, checks results.
`timescale 1ns / 100ps
module encoder_menu_navigator_checker #(
  parameter int MAX_ITEMS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  emn_in_if                              req_i,
  emn_out_if                             res_i,
  input  logic                           cfg_we_i,
  input  logic [emn_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [emn_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int                             fail_count_o,
  output int                             pending_o
);
  import emn_pkg::*;

  typedef struct packed {
    logic [MENU_W-1:0]   open_menu;
    logic [CURSOR_W-1:0] cursor;
    logic                select_valid;
    logic [ID_W-1:0]     select_id;
    logic [CURSOR_W-1:0] select_index;
  } menu_view_t;

  // Register shadows, index 0 for the first encoder and 1 for the second
  logic [COUNT_W-1:0]  entry_count [2];
  logic [TIMER_W-1:0]  close_after;
  logic [ID_W-1:0]     select_ids [2];

  logic                last_a [2];
  logic [MENU_W-1:0]   shown_menu;
  logic [CURSOR_W-1:0] cursor_now;
  logic [TIMER_W-1:0]  ticks_left;

  menu_view_t views_due [$];
  int         failures = 0;

  // Zero entries act as one; the 4-bit cursor caps the span at 16
  function automatic int unsigned menu_span(logic [COUNT_W-1:0] n);
    int unsigned cap;
    cap = (MAX_ITEMS < 16) ? MAX_ITEMS : 16;
    if (n == '0) return 1;
    if (n > cap) return cap;
    return 32'(n);
  endfunction

  task automatic flag(string text);
    failures++;
    if (failures <= 10) $display("[%0t] mismatch: %s", $time, text);
  endtask

  task automatic predict_menu(input logic [1:0] op, input logic enc, input logic lvl,
                              input logic b, output menu_view_t view);
    logic [MENU_W-1:0] own;
    int unsigned       span;
    int unsigned       pos;
    view = '0;
    case (op)
      OP_TICK: begin
        if (ticks_left != '0) begin
          ticks_left = ticks_left - TIMER_W'(1);
          if (ticks_left == '0) begin
            shown_menu = MENU_NONE;
            cursor_now = '0;
          end
        end
      end
      OP_ROTATE: begin
        own = enc ? MENU_SLIP : MENU_BOOST;
        if (lvl != last_a[enc]) begin
          last_a[enc] = lvl;
          if (shown_menu != own) begin
            // first detent only opens this encoder's menu
            shown_menu = own;
            cursor_now = '0;
          end else begin
            span = menu_span(entry_count[enc]);
            pos  = 32'(cursor_now);
            if (lvl != b) pos++;
            else if (pos > 0) pos--;
            if (pos > span - 1) pos = span - 1;
            cursor_now = CURSOR_W'(pos);
          end
          ticks_left = close_after;
        end
      end
      OP_SWITCH: begin
        if (!lvl) begin
          view.select_valid = 1'b1;
          view.select_id    = select_ids[enc];
          view.select_index = cursor_now;
          shown_menu        = MENU_NONE;
          ticks_left        = '0;
        end
      end
      default: ;
    endcase
    view.open_menu = shown_menu;
    view.cursor    = cursor_now;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    menu_view_t seen;
    menu_view_t due;
    if (!rst_ni) begin
      entry_count[0] = RST_BOOST_COUNT;
      entry_count[1] = RST_SLIP_COUNT;
      close_after    = RST_TIMEOUT;
      select_ids[0]  = RST_ID;
      select_ids[1]  = RST_ID;
      last_a[0]      = 1'b1;
      last_a[1]      = 1'b1;
      shown_menu     = MENU_NONE;
      cursor_now     = '0;
      ticks_left     = '0;
      views_due.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_BOOST_COUNT: entry_count[0] = cfg_data_i[COUNT_W-1:0];
          REG_SLIP_COUNT:  entry_count[1] = cfg_data_i[COUNT_W-1:0];
          REG_TIMEOUT:     close_after    = cfg_data_i[TIMER_W-1:0];
          REG_BOOST_ID:    select_ids[0]  = cfg_data_i[ID_W-1:0];
          REG_SLIP_ID:     select_ids[1]  = cfg_data_i[ID_W-1:0];
          default: ;
        endcase
      end
      if (res_i.valid && res_i.ready) begin
        seen.open_menu    = res_i.open_menu;
        seen.cursor       = res_i.cursor;
        seen.select_valid = res_i.select_valid;
        seen.select_id    = res_i.select_id;
        seen.select_index = res_i.select_index;
        if (views_due.size() == 0) begin
          flag($sformatf("result with none expected: menu %0d cursor %0d select %0b",
                         seen.open_menu, seen.cursor, seen.select_valid));
        end else begin
          due = views_due.pop_front();
          if (seen.open_menu !== due.open_menu)
            flag($sformatf("open_menu got %0d, expected %0d", seen.open_menu, due.open_menu));
          if (seen.cursor !== due.cursor)
            flag($sformatf("cursor got %0d, expected %0d", seen.cursor, due.cursor));
          if (seen.select_valid !== due.select_valid)
            flag($sformatf("select_valid got %0b, expected %0b",
                           seen.select_valid, due.select_valid));
          if (seen.select_id !== due.select_id)
            flag($sformatf("select_id got %0d, expected %0d", seen.select_id, due.select_id));
          if (seen.select_index !== due.select_index)
            flag($sformatf("select_index got %0d, expected %0d",
                           seen.select_index, due.select_index));
        end
      end
      if (req_i.valid && req_i.ready) begin
        predict_menu(req_i.opcode, req_i.encoder_select, req_i.pin_level, req_i.level_b, due);
        views_due.push_back(due);
      end
    end
    pending_o    = views_due.size();
    fail_count_o = failures;
  end

endmodule

/* tb/sv/encoder_menu_navigator_tb.sv */
// Testbench top for the encoder menu navigator: clock, reset, request stimulus and verdict.
`timescale 1ns / 100ps
module encoder_menu_navigator_tb;
  import emn_pkg::*;

  localparam int         MAX_ITEMS   = 16;
  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int         PHASES      = 10;
  localparam int         PHASE_ITEMS = 88;
  localparam int         HOLD_CYCLES = 150;

  logic                  clk   = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    fail_count;
  int                    pending;

  logic sent_a [2];
  logic spin_up [2];
  bit   calm     = 1'b0;
  int   hold_req = 0;

  emn_in_if  req_ch ();
  emn_out_if res_ch ();

  encoder_menu_navigator #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_i       (req_ch),
    .out_o      (res_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  encoder_menu_navigator_checker #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .req_i        (req_ch),
    .res_i        (res_ch),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic int idle_gap();
    if (calm) return 0;
    return ($urandom_range(99) < 20) ? $urandom_range(1, 3) : 0;
  endfunction

  function automatic logic [COUNT_W-1:0] random_count();
    return ($urandom_range(9) < 8) ? COUNT_W'($urandom_range(1, 16))
                                   : COUNT_W'($urandom_range(31));
  endfunction

  function automatic logic [TIMER_W-1:0] random_timeout();
    case ($urandom_range(9))
      0:       return '0;
      1:       return TIMER_W'($urandom_range(65535));
      2, 3:    return TIMER_W'($urandom_range(20, 200));
      default: return TIMER_W'($urandom_range(1, 8));
    endcase
  endfunction

  // Hold the request until the handshake, then sometimes idle for a random gap
  task automatic send_req(input logic [1:0] op, input logic enc, input logic lvl,
                          input logic b);
    bit took;
    int gap;
    req_ch.valid          <= 1'b1;
    req_ch.opcode         <= op;
    req_ch.encoder_select <= enc;
    req_ch.pin_level      <= lvl;
    req_ch.level_b        <= b;
    if (op == OP_ROTATE) sent_a[enc] = lvl;
    do begin
      @(negedge clk);
      took = req_ch.ready;
      @(posedge clk);
    end while (!took);
    gap = idle_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  task automatic load_settings(input logic [COUNT_W-1:0] boost_cnt,
                               input logic [COUNT_W-1:0] slip_cnt,
                               input logic [TIMER_W-1:0] ticks,
                               input logic [ID_W-1:0] boost_id,
                               input logic [ID_W-1:0] slip_id);
    wait_drained();
    write_reg(REG_BOOST_COUNT, CFG_DATA_W'(boost_cnt));
    write_reg(REG_SLIP_COUNT,  CFG_DATA_W'(slip_cnt));
    write_reg(REG_TIMEOUT,     ticks);
    write_reg(REG_BOOST_ID,    CFG_DATA_W'(boost_id));
    write_reg(REG_SLIP_ID,     CFG_DATA_W'(slip_id));
    cfg_we <= 1'b0;
  endtask

  // Many real detents with a sticky direction, so the cursor reaches both ends
  task automatic random_item(output logic [1:0] op, output logic enc, output logic lvl,
                             output logic b);
    int roll;
    roll = $urandom_range(99);
    enc  = 1'($urandom_range(1));
    lvl  = 1'($urandom_range(1));
    b    = 1'($urandom_range(1));
    if (roll < 45) begin
      op  = OP_ROTATE;
      lvl = ~sent_a[enc];
      if ($urandom_range(9) == 0) spin_up[enc] = ~spin_up[enc];
      b = spin_up[enc] ? ~lvl : lvl;
      if ($urandom_range(9) == 0) b = ~b;
    end else if (roll < 55) begin
      op = OP_ROTATE;
    end else if (roll < 77) begin
      op = OP_TICK;
    end else if (roll < 88) begin
      op  = OP_SWITCH;
      lvl = 1'b0;
    end else if (roll < 95) begin
      op  = OP_SWITCH;
      lvl = 1'b1;
    end else begin
      op = OP_UNUSED;
    end
  endtask

  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        res_ch.ready <= 1'b0;
        hold_left--;
      end else if (calm) begin
        res_ch.ready <= 1'b1;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= 30);
      end
    end
  end

  initial begin : stimulus
    logic [1:0] op;
    logic       enc;
    logic       lvl;
    logic       b;
    req_ch.valid          <= 1'b0;
    req_ch.opcode         <= OP_TICK;
    req_ch.encoder_select <= 1'b0;
    req_ch.pin_level      <= 1'b1;
    req_ch.level_b        <= 1'b1;
    cfg_we                <= 1'b0;
    cfg_idx               <= REG_BOOST_COUNT;
    cfg_data              <= '0;
    sent_a[0]  = 1'b1;
    sent_a[1]  = 1'b1;
    spin_up[0] = 1'b1;
    spin_up[1] = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Default registers: idle cases, opening, stepping, press on a foreign menu
    send_req(OP_TICK,   1'b0, 1'b0, 1'b0);
    send_req(OP_UNUSED, 1'b1, 1'b1, 1'b1);
    send_req(OP_SWITCH, 1'b0, 1'b1, 1'b0);
    send_req(OP_SWITCH, 1'b1, 1'b0, 1'b0);
    send_req(OP_ROTATE, 1'b0, 1'b1, 1'b0);
    send_req(OP_ROTATE, 1'b0, 1'b0, 1'b1);
    send_req(OP_ROTATE, 1'b0, 1'b1, 1'b0);
    send_req(OP_ROTATE, 1'b0, 1'b0, 1'b0);
    send_req(OP_ROTATE, 1'b0, 1'b1, 1'b1);
    send_req(OP_ROTATE, 1'b1, 1'b0, 1'b0);
    send_req(OP_SWITCH, 1'b0, 1'b0, 1'b1);

    // Zero and oversized counts, short timeout, extreme ids
    load_settings(5'd0, 5'd31, 16'd2, 11'd2047, 11'd1);
    send_req(OP_ROTATE, 1'b0, 1'b0, 1'b1);
    send_req(OP_ROTATE, 1'b0, 1'b1, 1'b0);
    send_req(OP_TICK,   1'b1, 1'b1, 1'b1);
    send_req(OP_TICK,   1'b0, 1'b0, 1'b0);
    send_req(OP_TICK,   1'b0, 1'b0, 1'b0);
    send_req(OP_ROTATE, 1'b1, 1'b1, 1'b0);
    send_req(OP_ROTATE, 1'b1, 1'b0, 1'b1);
    send_req(OP_ROTATE, 1'b1, 1'b1, 1'b0);
    send_req(OP_ROTATE, 1'b1, 1'b0, 1'b1);
    send_req(OP_SWITCH, 1'b1, 1'b0, 1'b0);

    // Auto-close disabled
    load_settings(5'd16, 5'd1, 16'd0, 11'd0, 11'd2047);
    send_req(OP_ROTATE, 1'b1, 1'b1, 1'b1);
    send_req(OP_ROTATE, 1'b1, 1'b0, 1'b1);
    send_req(OP_TICK,   1'b0, 1'b1, 1'b0);
    send_req(OP_SWITCH, 1'b1, 1'b0, 1'b1);

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: load_settings(5'd16, 5'd16, 16'hFFFF, 11'd2047, 11'd2047);
        1: load_settings(5'd1, 5'd1, 16'd1, 11'd0, 11'd0);
        2: load_settings(5'd0, 5'd31, 16'd3, ID_W'($urandom_range(2047)),
                         ID_W'($urandom_range(2047)));
        default: begin
          load_settings(random_count(), random_count(), random_timeout(),
                        ID_W'($urandom_range(2047)), ID_W'($urandom_range(2047)));
        end
      endcase
      calm = (p == 3);
      // stall the result side while requests keep coming, so the queue backs up
      if (p == 5) hold_req = HOLD_CYCLES;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 6 && n == PHASE_ITEMS / 2) wait_drained();
        random_item(op, enc, lvl, b);
        send_req(op, enc, lvl, b);
      end
    end
    calm = 1'b0;

    wait_drained();
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
